// ----- src/line_offset_table_lookup_core_assert.svh -----
// Assertion macros for the line offset table lookup core.
// Expects clk and rst in the scope of each use.
`ifndef LINE_OFFSET_TABLE_LOOKUP_CORE_ASSERT_SVH
`define LINE_OFFSET_TABLE_LOOKUP_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LOTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define LOTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lotl_pkg.sv -----
// Shared types and constants for the line offset table lookup core.
// No dependencies; used by lotl_bisect and line_offset_table_lookup_core.
package lotl_pkg;

  localparam int MAX_LINES = 4096;
  localparam int POS_BITS  = 32;
  localparam int IDX_W     = $clog2(MAX_LINES);
  localparam int CNT_W     = IDX_W + 1;

  // Opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;
  localparam logic [1:0] OP_BOUNDS = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [POS_BITS-1:0] start_offset;
    logic [POS_BITS-1:0] position;
    logic [11:0]         line_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [11:0]         line_index;
    logic [POS_BITS-1:0] column;
    logic [POS_BITS-1:0] line_begin;
    logic [POS_BITS-1:0] line_length;
  } out_item_t;

  // One bisection step: new bounds, next probe and loop exit
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] lo_next;
    logic [CNT_W-1:0] hi_next;
    logic [IDX_W-1:0] mid_next;
  } bisect_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_BOUNDS,
    ST_RESULT
  } state_t;

endpackage

// ----- src/lotl_bisect.sv -----
// Bisection step unit: compares the probed entries against the position
// and picks the next bounds and probe. Depends on lotl_pkg.
module lotl_bisect (
  input  logic [lotl_pkg::CNT_W-1:0]    lo,
  input  logic [lotl_pkg::CNT_W-1:0]    hi,
  input  logic [lotl_pkg::IDX_W-1:0]    mid,
  input  logic [lotl_pkg::POS_BITS-1:0] mid_data,
  input  logic [lotl_pkg::POS_BITS-1:0] next_data,
  input  logic [lotl_pkg::POS_BITS-1:0] pos,
  output lotl_pkg::bisect_t             step
);
  import lotl_pkg::*;

  logic [CNT_W-1:0] mid_w;
  logic [CNT_W-1:0] mid1;
  logic [CNT_W-1:0] cand_lo;
  logic [CNT_W-1:0] cand_hi;
  logic             gt_mid;
  logic             gt_next;

  // Compare both probes and form both candidate midpoints in parallel
  always_comb begin
    mid_w   = {1'b0, mid};
    mid1    = mid_w + CNT_W'(1);
    gt_mid  = mid_data > pos;
    gt_next = next_data > pos;
    cand_lo = lo + ((mid_w - lo) >> 1);
    cand_hi = mid1 + ((hi - mid1) >> 1);
  end

  // Shrink the window toward the last entry not above the position
  always_comb begin
    if (gt_mid) begin
      step.lo_next  = lo;
      step.hi_next  = mid_w;
      step.mid_next = cand_lo[IDX_W-1:0];
      step.done     = lo >= mid_w;
    end else begin
      step.lo_next  = mid1;
      step.hi_next  = hi;
      step.mid_next = cand_hi[IDX_W-1:0];
      step.done     = (mid1 >= hi) || gt_next;
    end
  end

endmodule

// ----- src/line_offset_table_lookup_core.sv -----
// Channel | handshake          | payload
// input   | in_valid, in_stall | in_item  (opcode, start_offset, position, line_number)
// output  | out_valid, out_stall| out_item (status, line_index, column, line_begin,
//         |                    |           line_length)
//
// Append, unknown opcodes and an out-of-range line bounds query go from IDLE
// straight to RESULT, an in-range line bounds query passes through BOUNDS, a
// position lookup through LOOK for k bisection steps (at most 13 for 4096
// entries); one step per cycle, set by the registered read of the line table.
// After rst the table holds one line starting at 0; no clearing pass is needed.
// A stalled result waits in the output register; the core accepts the next
// item once the result has moved there.
//
// Line start table with bisection lookup. Depends on lotl_pkg, lotl_bisect
// and the assertion macro header.
`include "line_offset_table_lookup_core_assert.svh"

module line_offset_table_lookup_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lotl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lotl_pkg::out_item_t out_item
);
  import lotl_pkg::*;

  state_t              state_q;
  state_t              state_next;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    lo_q;
  logic [CNT_W-1:0]    hi_q;
  logic [IDX_W-1:0]    mid_q;
  logic [POS_BITS-1:0] pos_q;
  logic                last_q;
  out_item_t           res_q;
  out_item_t           res_init;

  logic [POS_BITS-1:0] mem [MAX_LINES];
  logic [POS_BITS-1:0] rd_a;
  logic [POS_BITS-1:0] rd_b;
  logic                zero_a;
  logic [POS_BITS-1:0] d_a;

  logic [IDX_W-1:0]    addr_a;
  logic [IDX_W-1:0]    addr_b;
  logic                wr_en;
  logic                out_load;
  logic                accept;
  logic                full;
  logic                out_of_range;
  logic [POS_BITS-1:0] sub_a;
  logic [POS_BITS-1:0] diff;
  bisect_t             bis;

  assign accept       = in_valid && (state_q == ST_IDLE);
  assign full         = cnt_q == CNT_W'(MAX_LINES);
  assign out_of_range = {1'b0, in_item.line_number} >= cnt_q;

  // Entry zero is never written; it reads as zero
  assign d_a = zero_a ? '0 : rd_a;

  // Shared subtractor: column during lookup, line length during bounds
  assign sub_a = (state_q == ST_LOOK) ? pos_q : rd_b;
  assign diff  = sub_a - d_a;

  lotl_bisect u_bisect (
    .lo        (lo_q),
    .hi        (hi_q),
    .mid       (mid_q),
    .mid_data  (d_a),
    .next_data (rd_b),
    .pos       (pos_q),
    .step      (bis)
  );

  // Drive sequencer outputs: handshake, table addresses, write and result load
  always_comb begin
    in_stall = state_q != ST_IDLE;
    addr_a   = mid_q;
    addr_b   = mid_q + IDX_W'(1);
    wr_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_item.opcode == OP_LOCATE) begin
          addr_a = cnt_q[CNT_W-1:1];
        end else begin
          addr_a = in_item.line_number;
        end
        addr_b = addr_a + IDX_W'(1);
        wr_en  = accept && (in_item.opcode == OP_APPEND) && !full;
      end
      ST_LOOK: begin
        addr_a = bis.mid_next;
        addr_b = bis.mid_next + IDX_W'(1);
      end
      ST_BOUNDS: begin
      end
      ST_RESULT: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  // Pick the next sequencer state
  always_comb begin
    state_next = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.opcode == OP_LOCATE) begin
            state_next = ST_LOOK;
          end else if (in_item.opcode == OP_BOUNDS && !out_of_range) begin
            state_next = ST_BOUNDS;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_LOOK: begin
        if (bis.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_BOUNDS: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Form the cleared result for a new item, with its early status
  always_comb begin
    res_init = '0;
    if (in_item.opcode == OP_APPEND && full) begin
      res_init.status = STATUS_FULL;
    end else if (in_item.opcode == OP_BOUNDS && out_of_range) begin
      res_init.status = STATUS_RANGE;
    end
  end

  // Line table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= in_item.start_offset;
    end
    rd_a   <= mem[addr_a];
    rd_b   <= mem[addr_b];
    zero_a <= addr_a == '0;
  end

  // Control state: sequencer, line count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q   <= ST_IDLE;
      cnt_q     <= CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state_q <= state_next;
      if (wr_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q  <= in_item.position;
      lo_q   <= '0;
      hi_q   <= cnt_q;
      mid_q  <= cnt_q[CNT_W-1:1];
      last_q <= ({1'b0, in_item.line_number} + CNT_W'(1)) >= cnt_q;
      res_q  <= res_init;
    end
    // Advance the bisection; capture line and column on exit
    if (state_q == ST_LOOK) begin
      lo_q  <= bis.lo_next;
      hi_q  <= bis.hi_next;
      mid_q <= bis.mid_next;
      if (bis.done) begin
        res_q.line_index <= mid_q;
        res_q.column     <= diff;
      end
    end
    if (state_q == ST_BOUNDS) begin
      res_q.line_begin  <= d_a;
      res_q.line_length <= last_q ? '0 : diff;
    end
    if (out_load) begin
      out_item <= res_q;
    end
  end

  `LOTL_ASSERT_NOW(a_count_range, 1'b1, cnt_q != '0 && cnt_q <= CNT_W'(MAX_LINES), "bad count")
  `LOTL_ASSERT_NEXT(a_append_grows, wr_en, cnt_q == $past(cnt_q) + CNT_W'(1), "append lost")
  `LOTL_ASSERT_NOW(a_window_open, state_q == ST_LOOK, lo_q < hi_q && hi_q <= cnt_q, "empty window")

endmodule

// ----- tb/sv/line_offset_table_lookup_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for line_offset_table_lookup_core: directed and random items
// checked against an in-bench model of the line start table. Needs lotl_pkg.
module line_offset_table_lookup_core_tb;
  import lotl_pkg::*;

  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam int         MAX_GAP      = 17;
  localparam int         DRAIN_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Model copy of the table and its fill level
  logic [POS_BITS-1:0] model_starts [MAX_LINES];
  logic [CNT_W-1:0]    model_count = CNT_W'(1);
  logic [POS_BITS-1:0] tail_offset = '0;

  out_item_t pending_answers [$];
  out_item_t answer_due;
  int        error_count = 0;
  bit        no_idle = 1'b0;

  line_offset_table_lookup_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  // Apply one item to the table model and return the answer it gives
  function automatic out_item_t table_answer(in_item_t item);
    out_item_t   ans;
    int unsigned lo, hi, mid;
    bit          found;
    ans = '0;
    case (item.opcode)
      OP_APPEND: begin
        if (model_count >= MAX_LINES) begin
          ans.status = STATUS_FULL;
        end else begin
          model_starts[model_count] = item.start_offset;
          model_count++;
        end
      end
      OP_LOCATE: begin
        // Bisect for the last entry not above the position
        lo = 0;
        hi = model_count;
        mid = 0;
        found = 1'b0;
        while (lo < hi && !found) begin
          mid = lo + (hi - lo) / 2;
          if (model_starts[mid] > item.position) begin
            hi = mid;
          end else if (mid + 1 >= hi || model_starts[mid + 1] > item.position) begin
            found = 1'b1;
          end else begin
            lo = mid + 1;
          end
        end
        ans.line_index = mid[11:0];
        ans.column = item.position - model_starts[mid];
      end
      OP_BOUNDS: begin
        if (item.line_number >= model_count) begin
          ans.status = STATUS_RANGE;
        end else begin
          ans.line_begin = model_starts[item.line_number];
          if (item.line_number + 1 < model_count) begin
            ans.line_length = model_starts[item.line_number + 1] - ans.line_begin;
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Build an item; fields the opcode ignores carry random noise
  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] value);
    in_item_t item;
    item.opcode       = op;
    item.start_offset = $urandom;
    item.position     = $urandom;
    item.line_number  = 12'($urandom);
    case (op)
      OP_APPEND: item.start_offset = value;
      OP_LOCATE: item.position     = value;
      OP_BOUNDS: item.line_number  = value[11:0];
      default: ;
    endcase
    return item;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  // Wait a random gap, present the item, hold it until accepted
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(table_answer(item));
  endtask

  // Stall results for a random number of cycles before each one
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest pending answer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no item pending", '0, 32'(out_item.status));
      end else begin
        answer_due = pending_answers.pop_front();
        if (out_item.status !== answer_due.status)
          report_mismatch("status", 32'(answer_due.status), 32'(out_item.status));
        if (out_item.line_index !== answer_due.line_index)
          report_mismatch("line_index", 32'(answer_due.line_index),
                          32'(out_item.line_index));
        if (out_item.column !== answer_due.column)
          report_mismatch("column", answer_due.column, out_item.column);
        if (out_item.line_begin !== answer_due.line_begin)
          report_mismatch("line_begin", answer_due.line_begin, out_item.line_begin);
        if (out_item.line_length !== answer_due.line_length)
          report_mismatch("line_length", answer_due.line_length, out_item.line_length);
      end
    end
  end

  // Query the single-line table left by reset
  task automatic test_reset_state();
    send_item(make_item(OP_LOCATE, 32'h0));
    send_item(make_item(OP_LOCATE, 32'hFFFF_FFFF));
    send_item(make_item(OP_BOUNDS, 0));
    send_item(make_item(OP_BOUNDS, 1));
    send_item(make_item(OP_BOUNDS, 4095));
  endtask

  // Zero-length lines, exact line starts, last line and unknown opcodes
  task automatic test_field_extremes();
    send_item(make_item(OP_APPEND, 32'd0));
    send_item(make_item(OP_APPEND, 32'd100));
    send_item(make_item(OP_APPEND, 32'd100));
    send_item(make_item(OP_APPEND, 32'd250));
    tail_offset = 32'd250;
    send_item(make_item(OP_LOCATE, 32'd0));
    send_item(make_item(OP_LOCATE, 32'd99));
    send_item(make_item(OP_LOCATE, 32'd100));
    send_item(make_item(OP_LOCATE, 32'd249));
    send_item(make_item(OP_LOCATE, 32'd250));
    send_item(make_item(OP_LOCATE, 32'hFFFF_FFFF));
    send_item(make_item(OP_BOUNDS, 0));
    send_item(make_item(OP_BOUNDS, 1));
    send_item(make_item(OP_BOUNDS, 2));
    send_item(make_item(OP_BOUNDS, 4));
    send_item(make_item(OP_BOUNDS, 5));
    send_item('1);
    send_item(make_item(OP_UNKNOWN, 0));
  endtask

  // Mostly sorted appends mixed with lookups, plus noise entries
  task automatic test_random_traffic(int count);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 31) begin
        tail_offset += $urandom_range(0, 2000);
        send_item(make_item(OP_APPEND, tail_offset));
      end else if (pick < 35) begin
        send_item(make_item(OP_APPEND, $urandom));
      end else if (pick < 70) begin
        if ($urandom_range(0, 7) == 0) send_item(make_item(OP_LOCATE, $urandom));
        else send_item(make_item(OP_LOCATE, $urandom_range(0, tail_offset + 3000)));
      end else if (pick < 95) begin
        if ($urandom_range(0, 7) == 0) send_item(make_item(OP_BOUNDS, $urandom_range(0, 4095)));
        else send_item(make_item(OP_BOUNDS, $urandom_range(0, model_count + 2)));
      end else begin
        send_item(make_item(OP_UNKNOWN, 0));
      end
    end
    no_idle = 1'b0;
  endtask

  // Fill every entry, ending on the top offset, then overflow
  task automatic test_table_full();
    int fill;
    fill = 0;
    while (model_count < MAX_LINES - 1) begin
      if (fill % 200 == 0) no_idle = ($urandom_range(0, 1) == 0);
      tail_offset += $urandom_range(1, 900);
      send_item(make_item(OP_APPEND, tail_offset));
      fill++;
    end
    no_idle = 1'b0;
    send_item(make_item(OP_APPEND, 32'hFFFF_FFFF));
    repeat (3) send_item(make_item(OP_APPEND, $urandom));
  endtask

  // Deep bisection and bounds over the full table
  task automatic test_full_lookups(int count);
    send_item(make_item(OP_LOCATE, 32'hFFFF_FFFF));
    send_item(make_item(OP_LOCATE, 32'hFFFF_FFFE));
    send_item(make_item(OP_LOCATE, 32'h0));
    send_item(make_item(OP_LOCATE, tail_offset));
    send_item(make_item(OP_BOUNDS, 4095));
    send_item(make_item(OP_BOUNDS, 4094));
    send_item(make_item(OP_BOUNDS, 0));
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: send_item(make_item(OP_LOCATE, $urandom));
        1: send_item(make_item(OP_LOCATE, $urandom_range(0, tail_offset)));
        2: send_item(make_item(OP_BOUNDS, $urandom_range(0, 4095)));
        default: send_item(make_item(OP_APPEND, $urandom));
      endcase
    end
  endtask

  initial begin
    model_starts[0] = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_field_extremes();
    test_random_traffic(800);
    test_table_full();
    test_full_lookups(60);

    // Drain outstanding results, then watch for strays
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("results still pending", '0, 32'(pending_answers.size()));

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
